// ===== design/adcscan_pkg.sv =====
// Shared types and constants for the three-channel ADC oversampling scan block.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package adcscan_pkg;

   localparam int SAMPLE_BITS       = 10;
   localparam int SAMPLES_PER_BLOCK = 16;
   localparam int COUNT_BITS        = $clog2(SAMPLES_PER_BLOCK);
   localparam int SUM_BITS          = SAMPLE_BITS + COUNT_BITS;
   localparam int RAW_BITS          = 16;

   localparam logic [COUNT_BITS-1:0] LAST_SAMPLE = COUNT_BITS'(SAMPLES_PER_BLOCK - 1);

   localparam logic [15:0] TEMP_PRESCALE     = 16'd24;
   localparam logic [15:0] OCXO_GAIN_RESET   = 16'd2400;
   localparam logic [15:0] PHASE_GAIN_RESET  = 16'd1289;
   localparam logic [15:0] TEMP_OFFSET_RESET = 16'd4039;
   localparam logic [15:0] TEMP_SLOPE_RESET  = 16'd4507;

   typedef enum logic [1:0] {
      CH_OSC   = 2'd0,
      CH_PHASE = 2'd1,
      CH_TEMP  = 2'd2
   } chan_type;

   typedef enum logic [1:0] {
      REG_OCXO_GAIN   = 2'd0,
      REG_PHASE_GAIN  = 2'd1,
      REG_TEMP_OFFSET = 2'd2,
      REG_TEMP_SLOPE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] ocxo_gain;
      logic [15:0] phase_gain;
      logic [15:0] temp_offset;
      logic [15:0] temp_slope;
   } cfg_type;

   // One finished block, handed from the front to the back
   typedef struct packed {
      chan_type              done_channel;
      chan_type              mux_channel;
      logic [SUM_BITS-1:0]   sum;
   } job_type;

endpackage

// ===== design/adcscan_front.sv =====
// Front end: accepts ADC samples, sums 16 per block and advances the channel scan.
// Pushes one job per finished block into the queue; depends on adcscan_pkg.
module adcscan_front
   import adcscan_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   q_full,
   output logic                   q_push,
   output job_type                q_job
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   chan_type              chan_ff, chan_in;
   logic [SUM_BITS-1:0]   sum_next;
   logic                  accept;
   logic                  last;
   chan_type              done_chan;
   chan_type              next_chan;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign last      = (count_ff == LAST_SAMPLE);
   assign sum_next  = sum_ff + SUM_BITS'(req_sample);

   always_comb begin
      unique case (chan_ff)
         CH_PHASE: begin
            done_chan = CH_PHASE;
            next_chan = CH_TEMP;
         end
         CH_TEMP: begin
            done_chan = CH_TEMP;
            next_chan = CH_OSC;
         end
         default: begin
            done_chan = CH_OSC;
            next_chan = CH_PHASE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      chan_in  = chan_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
            sum_in   = '0;
            chan_in  = next_chan;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_next;
         end
      end
   end

   assign q_push             = accept && last;
   assign q_job.done_channel = done_chan;
   assign q_job.mux_channel  = next_chan;
   assign q_job.sum          = sum_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         chan_ff  <= CH_OSC;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

// ===== design/adcscan_queue.sv =====
// Two-entry job queue between the sample front end and the scaling back end.
// Depends on adcscan_pkg for the job type.
module adcscan_queue
   import adcscan_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type pop_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full    = (fill_ff == 2'd2);
   assign valid   = (fill_ff != 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== design/adcscan_back.sv =====
// Back end: updates the channel raw value, scales it with one shared multiplier
// and holds the result in an output register; depends on adcscan_pkg.
module adcscan_back
   import adcscan_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_valid,
   input  job_type       q_job,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output chan_type      rsp_done_channel,
   output logic [15:0]   rsp_raw_value,
   output logic [15:0]   rsp_scaled_value,
   output chan_type      rsp_mux_channel
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRE,
      ST_MUL,
      ST_OUT
   } state_type;

   state_type     state_ff, state_in;
   chan_type      done_ff, done_in;
   chan_type      mux_ff, mux_in;
   logic [15:0]   raw_ff, raw_in;
   logic [15:0]   temp_ff, temp_in;
   logic [23:0]   diff_ff, diff_in;
   logic [25:0]   prod_ff, prod_in;
   logic          rsp_valid_ff, rsp_valid_in;
   chan_type      rsp_done_ff, rsp_done_in;
   chan_type      rsp_mux_ff, rsp_mux_in;
   logic [15:0]   rsp_raw_ff, rsp_raw_in;
   logic [15:0]   rsp_scaled_ff, rsp_scaled_in;

   logic [23:0]   mul_a;
   logic [15:0]   mul_b;
   logic [39:0]   mul_p;
   logic [15:0]   job_sum;
   logic [15:0]   temp_next;
   logic [12:0]   temp_t;
   logic          is_temp;

   assign mul_p   = mul_a * mul_b;
   assign job_sum = 16'(q_job.sum);
   assign is_temp = (done_ff == CH_TEMP);
   assign temp_t  = mul_p[20:8];

   // Leaky sum; zero marks a first block, which starts at sum times 4
   always_comb begin
      if (temp_ff == 16'd0) begin
         temp_next = {job_sum[13:0], 2'b00};
      end else begin
         temp_next = temp_ff - {2'b00, temp_ff[15:2]} + job_sum;
      end
   end

   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      mux_in        = mux_ff;
      raw_in        = raw_ff;
      temp_in       = temp_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_done_in   = rsp_done_ff;
      rsp_mux_in    = rsp_mux_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_scaled_in = rsp_scaled_ff;
      q_pop         = 1'b0;
      mul_a         = {8'b0, raw_ff};
      mul_b         = cfg.ocxo_gain;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               done_in = q_job.done_channel;
               mux_in  = q_job.mux_channel;
               if (q_job.done_channel == CH_TEMP) begin
                  raw_in   = temp_next;
                  temp_in  = temp_next;
                  state_in = ST_PRE;
               end else begin
                  raw_in   = job_sum;
                  state_in = ST_MUL;
               end
            end
         end
         ST_PRE: begin
            // t = raw * 24 >> 8, then subtract offset; only the low 24 bits matter later
            mul_b    = TEMP_PRESCALE;
            diff_in  = {11'b0, temp_t} - {8'b0, cfg.temp_offset};
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (is_temp) begin
               mul_a = diff_ff;
               mul_b = cfg.temp_slope;
            end else if (done_ff == CH_PHASE) begin
               mul_b = cfg.phase_gain;
            end
            prod_in  = mul_p[25:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_done_in   = done_ff;
               rsp_mux_in    = mux_ff;
               rsp_raw_in    = raw_ff;
               rsp_scaled_in = is_temp ? prod_ff[23:8] : prod_ff[25:10];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         temp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         temp_ff      <= temp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      done_ff       <= done_in;
      mux_ff        <= mux_in;
      raw_ff        <= raw_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_mux_ff    <= rsp_mux_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_scaled_ff <= rsp_scaled_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_done_channel = rsp_done_ff;
   assign rsp_mux_channel  = rsp_mux_ff;
   assign rsp_raw_value    = rsp_raw_ff;
   assign rsp_scaled_value = rsp_scaled_ff;

endmodule

// ===== design/adc_three_channel_oversample_scan.sv =====
// Three-channel ADC oversampling scan: 16-sample blocks, round-robin channels.
// Throughput: one sample per cycle while the job queue is not full; the back end shares
// one multiplier and steps each block through IDLE, MUL, OUT (oscillator, phase) or
// IDLE, PRE, MUL, OUT (internal temperature). A block's job reaches these states
// via the job queue; a stalled result fills the job queue and then stalls the input.
// Reset (synchronous): scan restarts at the oscillator channel with empty sums,
// the leaky temperature sum clears, and the registers return to their defaults.
module adc_three_channel_oversample_scan
   import adcscan_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_done_channel,
   output logic [15:0]            rsp_raw_value,
   output logic [15:0]            rsp_scaled_value,
   output logic [1:0]             rsp_mux_channel,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          csr_write;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;
   job_type       push_job;
   job_type       pop_job;
   chan_type      done_chan;
   chan_type      mux_chan;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_OCXO_GAIN:   cfg_in.ocxo_gain   = csr_pwdata[15:0];
            REG_PHASE_GAIN:  cfg_in.phase_gain  = csr_pwdata[15:0];
            REG_TEMP_OFFSET: cfg_in.temp_offset = csr_pwdata[15:0];
            REG_TEMP_SLOPE:  cfg_in.temp_slope  = csr_pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_OCXO_GAIN:   csr_prdata = {16'b0, cfg_ff.ocxo_gain};
         REG_PHASE_GAIN:  csr_prdata = {16'b0, cfg_ff.phase_gain};
         REG_TEMP_OFFSET: csr_prdata = {16'b0, cfg_ff.temp_offset};
         REG_TEMP_SLOPE:  csr_prdata = {16'b0, cfg_ff.temp_slope};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ocxo_gain   <= OCXO_GAIN_RESET;
         cfg_ff.phase_gain  <= PHASE_GAIN_RESET;
         cfg_ff.temp_offset <= TEMP_OFFSET_RESET;
         cfg_ff.temp_slope  <= TEMP_SLOPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adcscan_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   adcscan_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_job  (pop_job)
   );

   adcscan_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_job            (pop_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_done_channel (done_chan),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_mux_channel  (mux_chan)
   );

   assign rsp_done_channel = done_chan;
   assign rsp_mux_channel  = mux_chan;

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("job popped from an empty queue");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((done_chan == CH_OSC && mux_chan == CH_PHASE) ||
                     (done_chan == CH_PHASE && mux_chan == CH_TEMP) ||
                     (done_chan == CH_TEMP && mux_chan == CH_OSC)))
      else $error("next channel does not follow the finished channel");

   a_push_blocks_input: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_ready)
      else $error("sample taken while the job queue is full");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for adc_three_channel_oversample_scan: directed and random ADC
// samples, APB register writes between phases, and a predictor for every block result.
// Depends on adcscan_pkg and the block's RTL only.
module tb_top;
   import adcscan_pkg::*;

   localparam int LONG_HOLD      = 600;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RESET_CYCLES   = 12;

   typedef struct {
      chan_type    done_channel;
      logic [15:0] raw_value;
      logic [15:0] scaled_value;
      chan_type    mux_channel;
   } block_result_type;

   typedef enum int {
      BLOCK_RANDOM,
      BLOCK_ZERO,
      BLOCK_FULL
   } block_fill_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_done_channel;
   logic [15:0]            rsp_raw_value;
   logic [15:0]            rsp_scaled_value;
   logic [1:0]             rsp_mux_channel;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [3:0]             csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // Predictor state: scan position, running block sum and per-channel raw values
   chan_type          scan_channel = CH_OSC;
   logic [3:0]        samples_in_block = '0;
   logic [13:0]       partial_sum = '0;
   logic [15:0]       osc_raw_model = '0;
   logic [15:0]       phase_raw_model = '0;
   logic [15:0]       temp_leaky_model = '0;
   cfg_type           model_cfg = '{OCXO_GAIN_RESET, PHASE_GAIN_RESET,
                                    TEMP_OFFSET_RESET, TEMP_SLOPE_RESET};

   logic [SAMPLE_BITS-1:0] pending_samples[$];
   block_result_type       expected_blocks[$];
   block_result_type       expected_now;

   int unsigned samples_queued = 0;
   int unsigned samples_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned settings_loaded = 1;
   int unsigned error_count = 0;
   int unsigned sender_gap = 0;
   int unsigned receiver_stall = 0;
   int unsigned quiet_cycles = 0;
   bit          allow_idle = 1'b1;
   bit          long_hold_armed = 1'b0;
   bit          long_hold_taken = 1'b0;

   adc_three_channel_oversample_scan dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_done_channel (rsp_done_channel),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_mux_channel  (rsp_mux_channel),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   // Add one sample to the block; on the last sample of a block, update the channel
   // and queue the block result it must produce.
   task automatic accumulate_sample(input logic [SAMPLE_BITS-1:0] s);
      logic [13:0]      sum;
      logic [31:0]      t;
      logic [31:0]      d;
      logic [31:0]      p;
      block_result_type r;
      sum = partial_sum + 14'(s);
      if (samples_in_block != LAST_SAMPLE) begin
         partial_sum = sum;
         samples_in_block = samples_in_block + 4'd1;
      end else begin
         partial_sum = '0;
         samples_in_block = '0;
         case (scan_channel)
            CH_PHASE: begin
               phase_raw_model = 16'(sum);
               p = 32'(phase_raw_model) * 32'(model_cfg.phase_gain);
               r.done_channel = CH_PHASE;
               r.raw_value = phase_raw_model;
               r.scaled_value = p[25:10];
               r.mux_channel = CH_TEMP;
            end
            CH_TEMP: begin
               // a zero leaky sum always restarts from four times the block sum
               if (temp_leaky_model == '0)
                  temp_leaky_model = {sum, 2'b00};
               else
                  temp_leaky_model = temp_leaky_model - (temp_leaky_model >> 2) + 16'(sum);
               t = (32'(temp_leaky_model) * 32'(TEMP_PRESCALE)) >> 8;
               d = t - 32'(model_cfg.temp_offset);
               p = d * 32'(model_cfg.temp_slope);
               r.done_channel = CH_TEMP;
               r.raw_value = temp_leaky_model;
               r.scaled_value = p[23:8];
               r.mux_channel = CH_OSC;
            end
            default: begin
               osc_raw_model = 16'(sum);
               p = 32'(osc_raw_model) * 32'(model_cfg.ocxo_gain);
               r.done_channel = CH_OSC;
               r.raw_value = osc_raw_model;
               r.scaled_value = p[25:10];
               r.mux_channel = CH_PHASE;
            end
         endcase
         scan_channel = r.mux_channel;
         expected_blocks.push_back(r);
      end
   endtask

   // Sender: take samples from the pending queue, with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sender_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            accumulate_sample(req_sample);
            samples_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (sender_gap > 0) begin
               sender_gap--;
               req_valid <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 11) == 0) begin
               sender_gap = $urandom_range(0, 8);
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_valid <= 1'b1;
               req_sample <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each result transaction against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         receiver_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_blocks.size() == 0) begin
               $error("result with no block pending: channel %0d raw %0d",
                      rsp_done_channel, rsp_raw_value);
               error_count++;
            end else begin
               expected_now = expected_blocks.pop_front();
               if (rsp_done_channel !== expected_now.done_channel) begin
                  $error("done_channel: expected %0d, got %0d",
                         expected_now.done_channel, rsp_done_channel);
                  error_count++;
               end
               if (rsp_raw_value !== expected_now.raw_value) begin
                  $error("raw_value: expected %0d, got %0d",
                         expected_now.raw_value, rsp_raw_value);
                  error_count++;
               end
               if (rsp_scaled_value !== expected_now.scaled_value) begin
                  $error("scaled_value: expected %0d, got %0d",
                         expected_now.scaled_value, rsp_scaled_value);
                  error_count++;
               end
               if (rsp_mux_channel !== expected_now.mux_channel) begin
                  $error("mux_channel: expected %0d, got %0d",
                         expected_now.mux_channel, rsp_mux_channel);
                  error_count++;
               end
            end
         end
         if (receiver_stall > 0) begin
            receiver_stall--;
            rsp_ready <= 1'b0;
         end else if (long_hold_armed && !long_hold_taken) begin
            // hold off long enough for the block to back up and stall its input
            long_hold_taken = 1'b1;
            receiver_stall = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 9) == 0) begin
            receiver_stall = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic queue_block(input block_fill_type fill);
      logic [SAMPLE_BITS-1:0] s;
      for (int i = 0; i < SAMPLES_PER_BLOCK; i++) begin
         case (fill)
            BLOCK_ZERO: s = '0;
            BLOCK_FULL: s = '1;
            default:    s = SAMPLE_BITS'($urandom_range(0, 1023));
         endcase
         pending_samples.push_back(s);
         samples_queued++;
      end
   endtask

   // Mostly random blocks with some all-zero and full-scale ones, then a partial
   // block that carries over into the next register setting.
   task automatic queue_random_phase(input int blocks);
      int unsigned pick;
      int unsigned extra;
      for (int b = 0; b < blocks; b++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0)
            queue_block(BLOCK_ZERO);
         else if (pick == 1)
            queue_block(BLOCK_FULL);
         else
            queue_block(BLOCK_RANDOM);
      end
      extra = $urandom_range(0, SAMPLES_PER_BLOCK - 1);
      for (int i = 0; i < extra; i++) begin
         pending_samples.push_back(SAMPLE_BITS'($urandom_range(0, 1023)));
         samples_queued++;
      end
   endtask

   task automatic wait_until_drained();
      while (samples_accepted != samples_queued || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers over the APB port; only called while the block is idle
   task automatic load_settings(input cfg_type next_cfg);
      reg_index_type idx;
      for (int r = 0; r < 4; r++) begin
         idx = reg_index_type'(r);
         @(posedge clock);
         csr_psel <= 1'b1;
         csr_pwrite <= 1'b1;
         csr_penable <= 1'b0;
         csr_paddr <= {idx, 2'b00};
         csr_pwdata <= {16'h0000, next_cfg[63 - 16 * r -: 16]};
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
      end
      model_cfg = next_cfg;
      settings_loaded++;
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      c.ocxo_gain = 16'($urandom_range(0, 65535));
      c.phase_gain = 16'($urandom_range(0, 65535));
      c.temp_offset = 16'($urandom_range(0, 65535));
      c.temp_slope = 16'($urandom_range(0, 65535));
      return c;
   endfunction

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-scale and zero blocks on every channel at reset settings, plus two random ones.
      // The zero temperature block leaves the leaky sum empty, so the next one
      // starts over at four times its sum; the last one decays it with a zero sum.
      queue_block(BLOCK_FULL);
      queue_block(BLOCK_ZERO);
      queue_block(BLOCK_ZERO);
      queue_block(BLOCK_ZERO);
      queue_block(BLOCK_FULL);
      queue_block(BLOCK_FULL);
      queue_block(BLOCK_RANDOM);
      queue_block(BLOCK_RANDOM);
      queue_block(BLOCK_ZERO);
      wait_until_drained();

      load_settings('0);
      queue_random_phase(10);
      wait_until_drained();

      load_settings('1);
      long_hold_armed = 1'b1;
      queue_random_phase(10);
      wait_until_drained();

      load_settings(random_settings());
      queue_random_phase(10);
      wait_until_drained();

      load_settings(random_settings());
      queue_random_phase(10);
      wait_until_drained();

      // back-to-back traffic on both sides for the last phase
      load_settings('{OCXO_GAIN_RESET, PHASE_GAIN_RESET, TEMP_OFFSET_RESET,
                      TEMP_SLOPE_RESET});
      allow_idle = 1'b0;
      queue_random_phase(10);
      wait_until_drained();

      $display("tb_top: %0d samples in, %0d block results checked, %0d register settings",
               samples_accepted, results_checked, settings_loaded);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
